### hw/rtl/cipt_pkg.sv
// Shared types and constants for the CAN identifier period tracker.
package cipt_pkg;

  localparam int IdW          = 29;
  localparam int LenW         = 4;
  localparam int DataW        = 64;
  localparam int TickW        = 32;
  localparam int SlotW        = 7;
  localparam int CountW       = 8;
  localparam int StdIdShift   = 18;
  localparam int TableDepthDef = 128;
  localparam int QueueDepth   = 2;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [LenW-1:0]  len;
    logic [DataW-1:0] data;
    logic [TickW-1:0] now;
  } job_t;

  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic              is_new;
    logic              table_full;
    logic [TickW-1:0]  period;
    logic [IdW-1:0]    id;
    logic [LenW-1:0]   len;
    logic [DataW-1:0]  data;
    logic [CountW-1:0] count;
  } result_t;

endpackage

### hw/rtl/cipt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cipt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/cipt_front.sv
// Front end: takes frames, normalizes the identifier and queues search jobs.
module cipt_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [cipt_pkg::IdW-1:0]   raw_id,
  input  logic                     extended_flag,
  input  logic [cipt_pkg::LenW-1:0]  length_code,
  input  logic [cipt_pkg::DataW-1:0] payload,
  input  logic [cipt_pkg::TickW-1:0] now_ticks,
  output logic                     job_valid,
  input  logic                     job_ready,
  output cipt_pkg::job_t           job
);
  import cipt_pkg::*;

  job_t       q [QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  job_t       in_job;
  logic       push;
  logic       pop;

  always_comb begin
    in_job.id   = extended_flag ? raw_id : (raw_id >> StdIdShift);
    in_job.len  = length_code;
    in_job.data = payload;
    in_job.now  = now_ticks;
  end

  assign in_ready  = (fill != 2'(QueueDepth));
  assign job_valid = (fill != 2'd0);
  assign job       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'(QueueDepth))
    else $error("queue fill out of range");
`endif

endmodule

### hw/rtl/cipt_back.sv
// Back end: linear table search, timestamp update and result register.
module cipt_back #(
  parameter int TABLE_DEPTH = cipt_pkg::TableDepthDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  cipt_pkg::job_t     job_in,
  output logic               out_valid,
  input  logic               out_ready,
  output cipt_pkg::result_t  res
);
  import cipt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic              state;
  job_t              job;
  logic [CW-1:0]     entry_count;
  logic [CW-1:0]     scan_idx;
  logic [AW-1:0]     cmp_idx;
  logic              cmp_vld;
  logic [IdW-1:0]    id_rd;
  logic [TickW-1:0]  ls_rd;
  logic              hit;
  logic              scan_done;
  logic              room;
  logic              id_we;
  logic              ls_we;
  logic [AW-1:0]     wr_addr;
  logic [CW-1:0]     count_inc;
  logic [AW+SlotW-1:0]  hit_slot_w;
  logic [CW+SlotW-1:0]  new_slot_w;
  logic [CW+CountW-1:0] cnt_w;
  logic [CW+CountW-1:0] cnt_inc_w;

  assign hit        = (state == ST_SEARCH) && cmp_vld && (id_rd == job.id);
  assign scan_done  = (scan_idx == entry_count);
  assign room       = (entry_count < CW'(TABLE_DEPTH));
  assign count_inc  = entry_count + CW'(1);
  assign id_we      = (state == ST_SEARCH) && !hit && scan_done && room;
  assign ls_we      = hit || id_we;
  assign wr_addr    = hit ? cmp_idx : entry_count[AW-1:0];
  assign job_ready  = (state == ST_IDLE) && !out_valid;
  assign hit_slot_w = {{SlotW{1'b0}}, cmp_idx};
  assign new_slot_w = {{SlotW{1'b0}}, entry_count};
  assign cnt_w      = {{CountW{1'b0}}, entry_count};
  assign cnt_inc_w  = {{CountW{1'b0}}, count_inc};

  cipt_ram #(.WIDTH(IdW), .DEPTH(TABLE_DEPTH)) u_id_ram (
    .clk     (clk),
    .we      (id_we),
    .wr_addr (wr_addr),
    .wr_data (job.id),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (id_rd)
  );

  cipt_ram #(.WIDTH(TickW), .DEPTH(TABLE_DEPTH)) u_ls_ram (
    .clk     (clk),
    .we      (ls_we),
    .wr_addr (wr_addr),
    .wr_data (job.now),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (ls_rd)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && job_valid && job_ready) begin
      job <= job_in;
    end
    if (state == ST_SEARCH && (hit || scan_done)) begin
      res.id   <= job.id;
      res.len  <= job.len;
      res.data <= job.data;
      if (hit) begin
        res.slot       <= hit_slot_w[SlotW-1:0];
        res.is_new     <= 1'b0;
        res.table_full <= 1'b0;
        res.period     <= job.now - ls_rd;
        res.count      <= cnt_w[CountW-1:0];
      end else if (room) begin
        res.slot       <= new_slot_w[SlotW-1:0];
        res.is_new     <= 1'b1;
        res.table_full <= 1'b0;
        res.period     <= '0;
        res.count      <= cnt_inc_w[CountW-1:0];
      end else begin
        res.slot       <= '0;
        res.is_new     <= 1'b0;
        res.table_full <= 1'b1;
        res.period     <= '0;
        res.count      <= cnt_w[CountW-1:0];
      end
    end
  end

  // read data follows the address in the next cycle; cmp_idx tracks it
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      entry_count <= '0;
      scan_idx    <= '0;
      cmp_idx     <= '0;
      cmp_vld     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (job_valid && job_ready) begin
            scan_idx <= '0;
            cmp_vld  <= 1'b0;
            state    <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (hit || scan_done) begin
            out_valid <= 1'b1;
            cmp_vld   <= 1'b0;
            state     <= ST_IDLE;
            if (id_we) begin
              entry_count <= count_inc;
            end
          end else begin
            cmp_idx  <= scan_idx[AW-1:0];
            cmp_vld  <= 1'b1;
            scan_idx <= scan_idx + CW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (entry_count != $past(entry_count)) |->
      (entry_count == $past(entry_count) + CW'(1)))
    else $error("entry count moved by other than one");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res.is_new && res.table_full))
    else $error("new and full flagged together");

  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_ready |-> !out_valid && (state == ST_IDLE))
    else $error("job taken while result register busy");
`endif

endmodule

### hw/rtl/can_id_period_tracker.sv
// The search walks the identifier RAM one entry per cycle, and a new frame enters the
// back end only once the search is done and the last result has left the result register.
// Frames are handled one at a time, with a two-deep queue ahead and a result register behind.
// Reset clears the entry count, queue and result valid; the RAMs are not cleared.
module can_id_period_tracker #(
  parameter int TABLE_DEPTH = cipt_pkg::TableDepthDef
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cipt_pkg::IdW-1:0]    raw_id,
  input  logic                      extended_flag,
  input  logic [cipt_pkg::LenW-1:0]   length_code,
  input  logic [cipt_pkg::DataW-1:0]  payload,
  input  logic [cipt_pkg::TickW-1:0]  now_ticks,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [cipt_pkg::SlotW-1:0]  slot,
  output logic                      is_new,
  output logic                      table_full,
  output logic [cipt_pkg::TickW-1:0]  period_ticks,
  output logic [cipt_pkg::IdW-1:0]    norm_id,
  output logic [cipt_pkg::LenW-1:0]   length_out,
  output logic [cipt_pkg::DataW-1:0]  payload_out,
  output logic [cipt_pkg::CountW-1:0] unique_count
);
  import cipt_pkg::*;

  job_t    job;
  logic    job_valid;
  logic    job_ready;
  result_t res;

  cipt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .raw_id        (raw_id),
    .extended_flag (extended_flag),
    .length_code   (length_code),
    .payload       (payload),
    .now_ticks     (now_ticks),
    .job_valid     (job_valid),
    .job_ready     (job_ready),
    .job           (job)
  );

  cipt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_in    (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign slot         = res.slot;
  assign is_new       = res.is_new;
  assign table_full   = res.table_full;
  assign period_ticks = res.period;
  assign norm_id      = res.id;
  assign length_out   = res.len;
  assign payload_out  = res.data;
  assign unique_count = res.count;

endmodule
